// ----- design/pftd_pkg.sv -----
// Shared types, register indexes and reset values for the PAL frame timing sequencer.
package pftd_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_PORCH  = 3'd0;
	localparam logic [2:0] REG_VSYNC  = 3'd1;
	localparam logic [2:0] REG_TOP    = 3'd2;
	localparam logic [2:0] REG_BOTTOM = 3'd3;
	localparam logic [2:0] REG_ACTIVE = 3'd4;
	localparam logic [2:0] REG_WORDS  = 3'd5;
	localparam logic [2:0] REG_HSYNC  = 3'd6;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 10;
	localparam int InDataW   = 8;
	localparam int OutDataW  = 40;

	// reset values of the timing registers
	localparam logic [7:0] PORCH_RST  = 8'd12;
	localparam logic [7:0] VSYNC_RST  = 8'd15;
	localparam logic [7:0] TOP_RST    = 8'd24;
	localparam logic [7:0] BOTTOM_RST = 8'd24;
	localparam logic [8:0] ACTIVE_RST = 9'd240;
	localparam logic [9:0] WORDS_RST  = 10'd24;
	localparam logic [7:0] HSYNC_RST  = 8'd4;

	typedef enum logic [2:0] {
		PH_FRONT  = 3'd0,
		PH_VSYNC  = 3'd1,
		PH_BACK   = 3'd2,
		PH_TOP    = 3'd3,
		PH_VIDEO  = 3'd4,
		PH_BOTTOM = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] porch_lines;
		logic [7:0] vsync_lines;
		logic [7:0] top_border_lines;
		logic [7:0] bottom_border_lines;
		logic [8:0] active_lines;
		logic [9:0] words_per_line;
		logic [7:0] hsync_words;
	} cfg_t;

	typedef struct packed {
		logic        next_is_sync;
		logic        frame_toggle;
		logic [9:0]  next_length;
		logic [18:0] row_word_offset;
		logic        from_video;
		logic        sync_level;
	} result_t;

endpackage

// ----- design/pftd_cfg.sv -----
// Timing configuration registers written through the plain write port.
module pftd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pftd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [pftd_pkg::CfgDataW-1:0]  cfg_wdata,
	output pftd_pkg::cfg_t                cfg
);

	pftd_pkg::cfg_t cfg_q;

	// write the addressed register, ignore unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.porch_lines         <= pftd_pkg::PORCH_RST;
			cfg_q.vsync_lines         <= pftd_pkg::VSYNC_RST;
			cfg_q.top_border_lines    <= pftd_pkg::TOP_RST;
			cfg_q.bottom_border_lines <= pftd_pkg::BOTTOM_RST;
			cfg_q.active_lines        <= pftd_pkg::ACTIVE_RST;
			cfg_q.words_per_line      <= pftd_pkg::WORDS_RST;
			cfg_q.hsync_words         <= pftd_pkg::HSYNC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pftd_pkg::REG_PORCH:  cfg_q.porch_lines         <= cfg_wdata[7:0];
				pftd_pkg::REG_VSYNC:  cfg_q.vsync_lines         <= cfg_wdata[7:0];
				pftd_pkg::REG_TOP:    cfg_q.top_border_lines    <= cfg_wdata[7:0];
				pftd_pkg::REG_BOTTOM: cfg_q.bottom_border_lines <= cfg_wdata[7:0];
				pftd_pkg::REG_ACTIVE: cfg_q.active_lines        <= cfg_wdata[8:0];
				pftd_pkg::REG_WORDS:  cfg_q.words_per_line      <= cfg_wdata[9:0];
				pftd_pkg::REG_HSYNC:  cfg_q.hsync_words         <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/pftd_core.sv -----
// Segment and vertical phase state with the next-result logic for one event.
module pftd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pftd_pkg::cfg_t    cfg,
	input  logic              step,
	output pftd_pkg::result_t res
);

	pftd_pkg::phase_t phase_q, phase_d;
	logic [8:0]       line_q, line_d;
	logic             in_sync_q, in_sync_d;

	logic [8:0]  line_inc;
	logic [8:0]  limit;
	logic        over;
	logic [8:0]  row;
	logic [18:0] product;

	assign line_inc = line_q + 9'd1;
	assign row      = line_inc - 9'd1;
	assign product  = 19'(row * cfg.words_per_line);

	// pick the line limit of the current phase
	always_comb begin
		unique case (phase_q)
			pftd_pkg::PH_VSYNC:  limit = {1'b0, cfg.vsync_lines};
			pftd_pkg::PH_BACK:   limit = {1'b0, cfg.porch_lines};
			pftd_pkg::PH_TOP:    limit = {1'b0, cfg.top_border_lines};
			pftd_pkg::PH_VIDEO:  limit = cfg.active_lines;
			pftd_pkg::PH_BOTTOM: limit = {1'b0, cfg.bottom_border_lines};
			default:             limit = {1'b0, cfg.porch_lines};
		endcase
	end

	assign over = (line_inc >= limit);

	// next state and result fields for one event
	always_comb begin
		phase_d   = phase_q;
		line_d    = line_q;
		in_sync_d = in_sync_q;
		res       = '0;
		if (!in_sync_q) begin
			// line segment ended: set up the sync segment
			res.next_length  = {2'b00, cfg.hsync_words};
			res.next_is_sync = 1'b1;
			in_sync_d        = 1'b1;
		end else begin
			line_d    = over ? 9'd0 : line_inc;
			in_sync_d = 1'b0;
			res.next_length = (cfg.words_per_line == 10'd0) ? 10'd0
			                  : cfg.words_per_line - 10'd1;
			unique case (phase_q)
				pftd_pkg::PH_VSYNC: begin
					res.sync_level = over;
					if (over) phase_d = pftd_pkg::PH_BACK;
				end
				pftd_pkg::PH_BACK: begin
					res.sync_level = 1'b1;
					if (over) phase_d = pftd_pkg::PH_TOP;
				end
				pftd_pkg::PH_TOP: begin
					res.sync_level = 1'b1;
					if (over) phase_d = pftd_pkg::PH_VIDEO;
				end
				pftd_pkg::PH_VIDEO: begin
					res.sync_level      = 1'b1;
					res.from_video      = 1'b1;
					res.row_word_offset = product;
					if (over) phase_d = pftd_pkg::PH_BOTTOM;
				end
				pftd_pkg::PH_BOTTOM: begin
					res.sync_level = 1'b1;
					if (over) phase_d = pftd_pkg::PH_FRONT;
				end
				default: begin
					// front porch and unused codes
					res.frame_toggle = over;
					res.sync_level   = !over;
					if (over) phase_d = pftd_pkg::PH_VSYNC;
				end
			endcase
		end
	end

	// advance state once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pftd_pkg::PH_FRONT;
			line_q    <= 9'd0;
			in_sync_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			line_q    <= line_d;
			in_sync_q <= in_sync_d;
		end
	end

endmodule

// ----- design/pal_frame_timing_dma_sequencer.sv -----
// Top level of the PAL frame timing sequencer: input register, core and result register.
//
// channel  direction  payload (low bit first)
// s_*      in         tdata[0] segment_done, tdata[7:1] zero
// m_*      out        tdata: sync_level, from_video, row_word_offset[18:0],
//                     next_length[9:0], frame_toggle, next_is_sync, zero fill to 40 bits
// cfg_*    in         write enable, register index, write data
//
// One beat per cycle sustained while the result side is not stalled; a beat is held in
// the input register and its result is then loaded into the result register. A beat
// with segment_done low is consumed with no result. Reset clears the phase state and
// both valid flags and loads the timing registers with their defaults. A stalled
// result holds the input register, which in turn drops s_tready.
module pal_frame_timing_dma_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pftd_pkg::InDataW-1:0]   s_tdata,  // [0] segment_done
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pftd_pkg::OutDataW-1:0]  m_tdata,  // sync_level, from_video, row_word_offset,
	                                                 // next_length, frame_toggle, next_is_sync
	input  logic                           cfg_we,
	input  logic [pftd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [pftd_pkg::CfgDataW-1:0]  cfg_wdata
);

	pftd_pkg::cfg_t    cfg;
	pftd_pkg::result_t res;
	pftd_pkg::result_t out_q;

	logic valid_s1, done_s1;
	logic out_valid_q;
	logic out_free, adv_s1, step;

	pftd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pftd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.res    (res)
	);

	// result register can take a beat when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && done_s1 && out_free;
	assign adv_s1   = valid_s1 && (!done_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	// hold the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			done_s1 <= s_tdata[0];
		end
	end

	// load the result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_q};

endmodule

// ----- test/pal_frame_timing_dma_sequencer_checker.sv -----
// Checker for the PAL frame timing sequencer: predicts every segment setup and compares it.
module pal_frame_timing_dma_sequencer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [pftd_pkg::InDataW-1:0]   s_tdata,  // [0] segment_done
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [pftd_pkg::OutDataW-1:0]  m_tdata,  // sync_level, from_video, row_word_offset,
	                                                 // next_length, frame_toggle, next_is_sync
	input  logic                           cfg_we,
	input  logic [pftd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [pftd_pkg::CfgDataW-1:0]  cfg_wdata,
	output int                             errors,
	output int                             pending
);
	import pftd_pkg::*;

	cfg_t       timing;
	phase_t     phase;
	logic [8:0] line_cnt;
	logic       in_hsync;
	result_t    setup_q[$];
	result_t    got_beat;
	result_t    want_beat;

	initial begin
		errors = 0;
		pending = 0;
	end

	// work out what the block programs when the running segment ends
	function automatic result_t next_segment();
		result_t     r;
		logic [8:0]  limit;
		logic        ended;
		phase_t      nxt;
		logic [31:0] prod;
		r = '0;
		if (!in_hsync) begin
			// line segment over: set up the horizontal sync segment
			r.next_length = {2'b00, timing.hsync_words};
			r.next_is_sync = 1'b1;
			in_hsync = 1'b1;
		end else begin
			// sync segment over: count a line and set up the line segment
			line_cnt = line_cnt + 9'd1;
			r.sync_level = 1'b1;
			case (phase)
				PH_VSYNC: limit = {1'b0, timing.vsync_lines};
				PH_BACK: limit = {1'b0, timing.porch_lines};
				PH_TOP: limit = {1'b0, timing.top_border_lines};
				PH_VIDEO: limit = timing.active_lines;
				PH_BOTTOM: limit = {1'b0, timing.bottom_border_lines};
				default: limit = {1'b0, timing.porch_lines};
			endcase
			ended = (line_cnt >= limit);
			case (phase)
				PH_VSYNC: begin
					r.sync_level = ended;
					nxt = PH_BACK;
				end
				PH_BACK: nxt = PH_TOP;
				PH_TOP: nxt = PH_VIDEO;
				PH_VIDEO: begin
					prod = ({23'd0, line_cnt} - 32'd1) * {22'd0, timing.words_per_line};
					r.from_video = 1'b1;
					r.row_word_offset = prod[18:0];
					nxt = PH_BOTTOM;
				end
				PH_BOTTOM: nxt = PH_FRONT;
				// front porch; unused codes fall in here as well
				default: begin
					r.sync_level = !ended;
					r.frame_toggle = ended;
					nxt = PH_VSYNC;
				end
			endcase
			if (ended) begin
				line_cnt = '0;
				phase = nxt;
			end
			r.next_length = (timing.words_per_line == 10'd0) ? 10'd0 :
			                timing.words_per_line - 10'd1;
			in_hsync = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors = errors + 1;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.porch_lines = PORCH_RST;
			timing.vsync_lines = VSYNC_RST;
			timing.top_border_lines = TOP_RST;
			timing.bottom_border_lines = BOTTOM_RST;
			timing.active_lines = ACTIVE_RST;
			timing.words_per_line = WORDS_RST;
			timing.hsync_words = HSYNC_RST;
			phase = PH_FRONT;
			line_cnt = '0;
			in_hsync = 1'b0;
			setup_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			// compare a result beat with the oldest predicted setup
			if (m_tvalid && m_tready) begin
				got_beat = m_tdata[$bits(result_t)-1:0];
				if (setup_q.size() == 0) begin
					errors = errors + 1;
					$display("%0t: result beat expected none actual %0h", $time, m_tdata);
				end else begin
					want_beat = setup_q.pop_front();
					check_field("sync_level", int'(want_beat.sync_level),
					            int'(got_beat.sync_level));
					check_field("from_video", int'(want_beat.from_video),
					            int'(got_beat.from_video));
					check_field("row_word_offset", int'(want_beat.row_word_offset),
					            int'(got_beat.row_word_offset));
					check_field("next_length", int'(want_beat.next_length),
					            int'(got_beat.next_length));
					check_field("frame_toggle", int'(want_beat.frame_toggle),
					            int'(got_beat.frame_toggle));
					check_field("next_is_sync", int'(want_beat.next_is_sync),
					            int'(got_beat.next_is_sync));
				end
			end
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_PORCH: timing.porch_lines = cfg_wdata[7:0];
					REG_VSYNC: timing.vsync_lines = cfg_wdata[7:0];
					REG_TOP: timing.top_border_lines = cfg_wdata[7:0];
					REG_BOTTOM: timing.bottom_border_lines = cfg_wdata[7:0];
					REG_ACTIVE: timing.active_lines = cfg_wdata[8:0];
					REG_WORDS: timing.words_per_line = cfg_wdata[9:0];
					REG_HSYNC: timing.hsync_words = cfg_wdata[7:0];
					default: ;
				endcase
			end
			// a segment end with segment_done low leaves everything alone
			if (s_tvalid && s_tready && s_tdata[0])
				setup_q.push_back(next_segment());
			pending = setup_q.size();
		end
	end

endmodule

// ----- test/pal_frame_timing_dma_sequencer_tb.sv -----
// Testbench top: drives segment-end beats, timing register writes and result back-pressure.
module pal_frame_timing_dma_sequencer_tb;
	import pftd_pkg::*;

	localparam int QuietLimit  = 1000;
	localparam int DeepBeats   = 620;
	localparam int RandomBeats = 80;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata;  // [0] segment_done, rest zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OutDataW-1:0]  m_tdata;  // sync_level, from_video, row_word_offset,
	                                // next_length, frame_toggle, next_is_sync
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_wdata;
	logic                 no_idle = 1'b0;
	int                   errors;
	int                   pending;
	int                   quiet = 0;

	pal_frame_timing_dma_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	pal_frame_timing_dma_sequencer_checker timing_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one segment-end beat after a random gap; returns at the falling edge after it
	task automatic send_beat(input logic done);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(InDataW-1){1'b0}}, done};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// send the given number of real segment ends, with some ignored beats mixed in
	task automatic send_frame_beats(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 15) == 0) begin
				send_beat(1'b0);
			end else begin
				send_beat(1'b1);
				sent++;
			end
		end
	endtask

	task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// hold off until the block is idle, then load all timing registers
	task automatic write_timing(input logic [7:0] porch, input logic [7:0] vsync,
	                            input logic [7:0] top_lines, input logic [7:0] bottom_lines,
	                            input logic [8:0] active, input logic [9:0] words,
	                            input logic [7:0] hsync);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		put_reg(REG_PORCH, {2'b00, porch});
		put_reg(REG_VSYNC, {2'b00, vsync});
		put_reg(REG_TOP, {2'b00, top_lines});
		put_reg(REG_BOTTOM, {2'b00, bottom_lines});
		put_reg(REG_ACTIVE, {1'b0, active});
		put_reg(REG_WORDS, words);
		put_reg(REG_HSYNC, {2'b00, hsync});
		cfg_we <= 1'b0;
	endtask

	// mostly short lengths, sometimes the top value, one, or zero
	function automatic logic [9:0] pick_length(input int hi, input int typ);
		case ($urandom_range(0, 15))
			0: return hi[9:0];
			1: return 10'd1;
			2: return 10'd0;
			default: return 10'($urandom_range(1, typ));
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timing: an ignored beat, then the first lines of front porch
		send_beat(1'b0);
		repeat (6) send_beat(1'b1);

		// narrowest frame with the longest segments; the leftover count ends the phase at once
		write_timing(8'd1, 8'd1, 8'd1, 8'd1, 9'd2, 10'd1023, 8'd255);
		repeat (7) send_beat(1'b1);
		send_beat(1'b0);
		repeat (7) send_beat(1'b1);

		// zero line registers end each phase on its first line; zero words saturate
		write_timing(8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 10'd0, 8'd0);
		repeat (3) send_beat(1'b1);

		// tall picture with the widest lines reaches a large row offset
		write_timing(8'd1, 8'd1, 8'd1, 8'd1, 9'd300, 10'd1023, 8'd17);
		send_frame_beats(DeepBeats);

		// every register at its maximum, then random settings phase by phase
		write_timing(8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 10'd1023, 8'd255);
		no_idle <= 1'b1;
		send_frame_beats($urandom_range(40, 140));
		begin
			int total;
			int n;
			total = 0;
			while (total < RandomBeats) begin
				write_timing(8'(pick_length(255, 6)), 8'(pick_length(255, 6)),
				             8'(pick_length(255, 6)), 8'(pick_length(255, 6)),
				             9'(pick_length(511, 8)), pick_length(1023, 1023),
				             8'(pick_length(255, 255)));
				no_idle <= ($urandom_range(0, 3) == 0);
				n = $urandom_range(40, 140);
				send_frame_beats(n);
				total += n;
			end
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then let the pipeline settle
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[pal_frame_timing_dma_sequencer] OK");
		else
			$display("[pal_frame_timing_dma_sequencer] ERROR");
		$finish;
	end

	// result side: unless no_idle is set, hold m_tready low for a random stall before taking each beat
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet == QuietLimit) begin
			$display("[pal_frame_timing_dma_sequencer] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule
